/* design/ftht_pkg.sv */
// shared types, constants and helpers for the flicker hold tracker
// no dependencies; used by every module of the block
package ftht_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int WIN_W      = MAX_WINDOW;
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W      = $clog2(MAX_WINDOW);

  localparam int WLEN_W     = 6;
  localparam int THR_W      = 5;
  localparam int HOLD_W     = 8;
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int FIELD_W    = 16;

  localparam logic [WLEN_W-1:0] WLEN_RST = WLEN_W'(16);
  localparam logic [THR_W-1:0]  THR_RST  = THR_W'(8);
  localparam logic [HOLD_W-1:0] HOLD_RST = HOLD_W'(10);

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_THRESHOLD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY     = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    KIND_DETECT = 2'd0,
    KIND_COAST  = 2'd1,
    KIND_SPIN   = 2'd2
  } report_kind_e;

  typedef struct packed {
    report_kind_e               kind;
    logic signed [FIELD_W-1:0]  x;
    logic signed [FIELD_W-1:0]  y;
    logic signed [FIELD_W-1:0]  z;
    logic [FIELD_W-1:0]         distance;
    logic signed [FIELD_W-1:0]  pitch;
    logic signed [FIELD_W-1:0]  yaw;
  } result_t;

  // request to the flip scanner: shift in a flag and walk the newest pairs
  typedef struct packed {
    logic             start;
    logic             flag;
    logic [CNT_W-1:0] steps;
  } scan_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] flips;
  } scan_sts_t;

  // effective window length, clamped to 2..MAX_WINDOW
  function automatic logic [LEN_W-1:0] eff_len(logic [WLEN_W-1:0] wl);
    logic [LEN_W-1:0] len;
    if (int'(wl) < 2) begin
      len = LEN_W'(2);
    end else if (int'(wl) > MAX_WINDOW) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = LEN_W'(wl);
    end
    return len;
  endfunction

endpackage

/* design/ftht_flip_scan.sv */
// flag window shift register and bit-serial flip counter
// depends on ftht_pkg
module ftht_flip_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ftht_pkg::scan_req_t req_i,
  output ftht_pkg::scan_sts_t sts_o
);

  logic [ftht_pkg::WIN_W-1:0] window_q, window_d;
  logic [ftht_pkg::WIN_W-1:0] scan_q, scan_d;
  logic [ftht_pkg::CNT_W-1:0] steps_q, steps_d;
  logic [ftht_pkg::CNT_W-1:0] flips_q, flips_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  always_comb begin
    window_d = window_q;
    scan_d   = scan_q;
    steps_d  = steps_q;
    flips_d  = flips_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      window_d = {window_q[ftht_pkg::WIN_W-2:0], req_i.flag};
      scan_d   = {window_q[ftht_pkg::WIN_W-2:0], req_i.flag};
      steps_d  = req_i.steps;
      flips_d  = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      // one adjacent pair per cycle, newest first
      flips_d = flips_q + ftht_pkg::CNT_W'(scan_q[0] ^ scan_q[1]);
      scan_d  = scan_q >> 1;
      steps_d = steps_q - ftht_pkg::CNT_W'(1);
      if (steps_q == ftht_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      steps_q  <= '0;
      flips_q  <= '0;
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      window_q <= window_d;
      steps_q  <= steps_d;
      flips_q  <= flips_d;
      busy_q   <= busy_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
  end

  assign sts_o.done  = done_q;
  assign sts_o.flips = flips_q;

endmodule

/* design/ftht_out_reg.sv */
// output register for one result beat, valid/ready on the far side
// depends on ftht_pkg
module ftht_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ftht_pkg::result_t data_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output ftht_pkg::result_t data_o
);

  logic              valid_q;
  ftht_pkg::result_t data_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* design/target_flicker_hold_tracker.sv */
// top level of the flicker hold tracker: config, frame control, hold and centre state
// depends on ftht_pkg, ftht_flip_scan, ftht_out_reg
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  in       | in_valid_i / in_ready_o | detected, pos_x/y/z, distance, pitch, yaw
//  out      | out_valid_o/out_ready_i | report_kind, out_x/y/z, distance, pitch, yaw
//  cfg      | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// a frame goes through the accept cycle, then the scan state, in which the flip
// scanner walks the len-1 newest flag pairs one pair per cycle (len = clamped window
// length, 2..32) and raises its done flag, and last the decide state.
// reset clears all control state, loads the hold counter with 10 and the
// registers with their defaults. a beat waiting in the output register only
// stalls a frame that has a result to hand over; no new frame is taken meanwhile.
module target_flicker_hold_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        detected_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic [15:0] distance_i,
  input  logic signed [15:0] pitch_i,
  input  logic signed [15:0] yaw_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  report_kind_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic signed [15:0] out_z_o,
  output logic [15:0] out_distance_o,
  output logic signed [15:0] out_pitch_o,
  output logic signed [15:0] out_yaw_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

  state_e state_q;

  logic [ftht_pkg::WLEN_W-1:0] wlen_q;
  logic [ftht_pkg::THR_W-1:0]  thr_q;
  logic [ftht_pkg::HOLD_W-1:0] hold_delay_q;

  logic [ftht_pkg::LEN_W-1:0]  fill_q;
  logic [ftht_pkg::HOLD_W-1:0] hold_q;
  logic                        full_q;

  logic                           det_q;
  logic signed [ftht_pkg::FIELD_W-1:0] px_q, py_q, pz_q, pp_q, pw_q;
  logic [ftht_pkg::FIELD_W-1:0]        pd_q;

  logic signed [ftht_pkg::FIELD_W-1:0] cx_q, cy_q, cz_q, cp_q;
  logic [ftht_pkg::FIELD_W-1:0]        cd_q;

  logic [ftht_pkg::LEN_W-1:0] len;
  logic                       in_fire;
  logic                       spin;
  logic                       need_out;
  logic                       out_free;
  logic                       out_load;
  logic                       finish;

  ftht_pkg::scan_req_t scan_req;
  ftht_pkg::scan_sts_t scan_sts;
  ftht_pkg::result_t   res;
  ftht_pkg::result_t   out_data;

  assign len        = ftht_pkg::eff_len(wlen_q);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign scan_req.start = in_fire;
  assign scan_req.flag  = detected_i;
  assign scan_req.steps = ftht_pkg::CNT_W'(len - ftht_pkg::LEN_W'(1));

  ftht_flip_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scan_req),
    .sts_o  (scan_sts)
  );

  // the frame that fills the window does no flip check
  assign spin     = full_q && (int'(scan_sts.flips) > int'(thr_q));
  assign need_out = spin || det_q || (hold_q != '0);
  assign finish   = (state_q == S_DECIDE) && (!need_out || out_free);
  assign out_load = finish && need_out;

  always_comb begin
    res.kind     = ftht_pkg::KIND_DETECT;
    res.x        = px_q;
    res.y        = py_q;
    res.z        = pz_q;
    res.distance = pd_q;
    res.pitch    = pp_q;
    res.yaw      = pw_q;
    if (spin) begin
      res.kind     = ftht_pkg::KIND_SPIN;
      res.x        = cx_q;
      res.y        = cy_q;
      res.z        = cz_q;
      res.distance = cd_q;
      res.pitch    = cp_q;
      res.yaw      = '0;
    end else if (!det_q) begin
      res.kind = ftht_pkg::KIND_COAST;
      res.yaw  = '0;
    end
  end

  ftht_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .data_i  (res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign report_kind_o  = out_data.kind;
  assign out_x_o        = out_data.x;
  assign out_y_o        = out_data.y;
  assign out_z_o        = out_data.z;
  assign out_distance_o = out_data.distance;
  assign out_pitch_o    = out_data.pitch;
  assign out_yaw_o      = out_data.yaw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q       <= ftht_pkg::WLEN_RST;
      thr_q        <= ftht_pkg::THR_RST;
      hold_delay_q <= ftht_pkg::HOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ftht_pkg::CFG_WINDOW_LENGTH:  wlen_q       <= cfg_wdata_i[ftht_pkg::WLEN_W-1:0];
        ftht_pkg::CFG_FLIP_THRESHOLD: thr_q        <= cfg_wdata_i[ftht_pkg::THR_W-1:0];
        ftht_pkg::CFG_HOLD_DELAY:     hold_delay_q <= cfg_wdata_i[ftht_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      hold_q  <= ftht_pkg::HOLD_RST;
      full_q  <= 1'b0;
      cx_q    <= '0;
      cy_q    <= '0;
      cz_q    <= '0;
      cd_q    <= '0;
      cp_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            full_q <= (fill_q >= len);
            // saturate at the current length once the window counts as full
            if (fill_q >= len) begin
              fill_q <= len;
            end else begin
              fill_q <= fill_q + ftht_pkg::LEN_W'(1);
            end
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_sts.done) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (finish) begin
            if (spin) begin
              hold_q <= hold_delay_q;
            end else if (det_q) begin
              hold_q <= hold_delay_q;
              cx_q   <= px_q;
              cy_q   <= py_q;
              cz_q   <= pz_q;
              cd_q   <= pd_q;
              cp_q   <= pp_q;
            end else if (hold_q != '0) begin
              hold_q <= hold_q - ftht_pkg::HOLD_W'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      det_q <= detected_i;
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
      pz_q  <= pos_z_i;
      pd_q  <= distance_i;
      pp_q  <= pitch_i;
      pw_q  <= yaw_i;
    end
  end

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= ftht_pkg::MAX_WINDOW)
    else $error("window fill beyond maximum window");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_o || out_ready_i))
    else $error("result loaded over a beat that was not taken");

  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_sts.done |-> (state_q == S_SCAN))
    else $error("flip scan finished outside the scan state");

  a_coast_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (res.kind == ftht_pkg::KIND_COAST)) |=>
      (hold_q == $past(hold_q) - ftht_pkg::HOLD_W'(1)))
    else $error("coast report without a hold counter step");

endmodule

/* tb/ftht_tb_pkg.sv */
// frame type and pose scoreboard for the flicker hold tracker testbench
// depends on ftht_pkg for widths, register indexes, report kinds and result_t
package ftht_tb_pkg;
  import ftht_pkg::*;

  typedef struct packed {
    logic                      detected;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
    logic [FIELD_W-1:0]        distance;
    logic signed [FIELD_W-1:0] pitch;
    logic signed [FIELD_W-1:0] yaw;
  } frame_t;

  class ftht_pose_scoreboard;
    logic [WLEN_W-1:0] wlen_q;
    logic [THR_W-1:0]  thr_q;
    logic [HOLD_W-1:0] hold_q;
    logic [WIN_W-1:0]  flags;
    logic [WLEN_W-1:0] fill;
    logic [HOLD_W-1:0] hold_left;
    result_t           centre;
    result_t           expected_reports[$];
    int                mismatches;
    int                frames_seen;
    int                kind_seen[3];

    function new();
      wlen_q      = WLEN_RST;
      thr_q       = THR_RST;
      hold_q      = HOLD_RST;
      flags       = '0;
      fill        = '0;
      hold_left   = HOLD_RST;
      centre      = '0;
      mismatches  = 0;
      frames_seen = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_WINDOW_LENGTH:  wlen_q = data[WLEN_W-1:0];
        CFG_FLIP_THRESHOLD: thr_q  = data[THR_W-1:0];
        CFG_HOLD_DELAY:     hold_q = data[HOLD_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void add_expected(result_t r);
      expected_reports.insert(expected_reports.size(), r);
    endfunction

    // advance the tracker by one accepted frame and queue the report it causes
    function void note_frame(frame_t f);
      int unsigned      len;
      logic [WIN_W-1:0] pairs;
      bit               full;
      result_t          r;
      len = (wlen_q < 2) ? 2 : ((wlen_q > MAX_WINDOW) ? MAX_WINDOW : wlen_q);
      frames_seen++;
      full  = (fill >= len);
      flags = {flags[WIN_W-2:0], f.detected};
      if (!full) begin
        fill = fill + 1'b1;
      end else begin
        // only the len-1 newest adjacent pairs count, new flag included
        pairs = (flags ^ (flags >> 1)) & ((WIN_W'(1) << (len - 1)) - 1'b1);
        fill  = WLEN_W'(len);
        if ($countones(pairs) > thr_q) begin
          hold_left = hold_q;
          r         = centre;
          r.kind    = KIND_SPIN;
          r.yaw     = '0;
          add_expected(r);
          return;
        end
      end
      r.x        = f.x;
      r.y        = f.y;
      r.z        = f.z;
      r.distance = f.distance;
      r.pitch    = f.pitch;
      if (f.detected) begin
        centre    = r;
        hold_left = hold_q;
        r.kind    = KIND_DETECT;
        r.yaw     = f.yaw;
        add_expected(r);
      end else if (hold_left != '0) begin
        hold_left = hold_left - 1'b1;
        r.kind    = KIND_COAST;
        r.yaw     = '0;
        add_expected(r);
      end
    endfunction

    function void compare_field(string name, logic [FIELD_W-1:0] want,
                                logic [FIELD_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(result_t got);
      result_t want;
      if (expected_reports.size() == 0) begin
        $error("report_kind: expected no beat, got kind %0d x %h", got.kind, got.x);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      kind_seen[int'(want.kind)]++;
      compare_field("report_kind", FIELD_W'(want.kind), FIELD_W'(got.kind));
      compare_field("out_x", want.x, got.x);
      compare_field("out_y", want.y, got.y);
      compare_field("out_z", want.z, got.z);
      compare_field("out_distance", want.distance, got.distance);
      compare_field("out_pitch", want.pitch, got.pitch);
      compare_field("out_yaw", want.yaw, got.yaw);
    endfunction
  endclass

endpackage

/* tb/tb_target_flicker_hold_tracker.sv */
// testbench for target_flicker_hold_tracker: directed frames, then random flicker
// patterns under many register settings, with random stalls on both channels.
// depends on ftht_pkg and ftht_tb_pkg; every report is checked against the scoreboard
module tb_target_flicker_hold_tracker;
  import ftht_pkg::*;
  import ftht_tb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(3);
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 10;
  localparam int PHASE_FRAMES  = 83;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_idx_i;
  logic [CFG_W-1:0]          cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  frame_t                    frame_q;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [1:0]                report_kind_o;
  logic signed [FIELD_W-1:0] out_x_o;
  logic signed [FIELD_W-1:0] out_y_o;
  logic signed [FIELD_W-1:0] out_z_o;
  logic [FIELD_W-1:0]        out_distance_o;
  logic signed [FIELD_W-1:0] out_pitch_o;
  logic signed [FIELD_W-1:0] out_yaw_o;

  bit                  calm = 1'b0;
  int                  settings_used = 0;
  result_t             seen_report;
  ftht_pose_scoreboard poses;

  target_flicker_hold_tracker u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .detected_i     (frame_q.detected),
    .pos_x_i        (frame_q.x),
    .pos_y_i        (frame_q.y),
    .pos_z_i        (frame_q.z),
    .distance_i     (frame_q.distance),
    .pitch_i        (frame_q.pitch),
    .yaw_i          (frame_q.yaw),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .report_kind_o  (report_kind_o),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .out_z_o        (out_z_o),
    .out_distance_o (out_distance_o),
    .out_pitch_o    (out_pitch_o),
    .out_yaw_o      (out_yaw_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 31);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      poses.note_frame(frame_q);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_report.kind     = report_kind_e'(report_kind_o);
      seen_report.x        = out_x_o;
      seen_report.y        = out_y_o;
      seen_report.z        = out_z_o;
      seen_report.distance = out_distance_o;
      seen_report.pitch    = out_pitch_o;
      seen_report.yaw      = out_yaw_o;
      poses.check_report(seen_report);
    end
  end

  function automatic frame_t pose_frame(logic det, logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                                        logic [FIELD_W-1:0] z, logic [FIELD_W-1:0] d,
                                        logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] w);
    frame_t f;
    f.detected = det;
    f.x        = x;
    f.y        = y;
    f.z        = z;
    f.distance = d;
    f.pitch    = p;
    f.yaw      = w;
    return f;
  endfunction

  // mostly uniform, now and then a corner value
  function automatic logic [FIELD_W-1:0] pick_field();
    logic [FIELD_W-1:0] v;
    v = FIELD_W'($urandom);
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: v = 16'h8000;
        1: v = 16'h7fff;
        2: v = '0;
        default: v = '1;
      endcase
    end
    return v;
  endfunction

  function automatic frame_t random_frame(logic det);
    return pose_frame(det, pick_field(), pick_field(), pick_field(), pick_field(),
                      pick_field(), pick_field());
  endfunction

  task automatic send_frame(input frame_t f);
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    frame_q    <= f;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    poses.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_setting(input int wlen, input int thr, input int hold);
    write_reg(CFG_WINDOW_LENGTH, CFG_W'(wlen));
    write_reg(CFG_FLIP_THRESHOLD, CFG_W'(thr));
    write_reg(CFG_HOLD_DELAY, CFG_W'(hold));
    settings_used++;
  endtask

  // stop sending, wait for every report, then let a frame that reports nothing finish
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (poses.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [5:0] spin_seq;
    logic [5:0] toggle_seq;
    logic       det;
    int         flip_pct;
    int         wlen;
    int         thr;
    int         hold;
    poses       = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_WINDOW_LENGTH;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    frame_q     = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, window still filling: field extremes, detect then coast
    send_frame(pose_frame(1'b1, 16'h7fff, 16'h8000, 16'hffff, 16'hffff, 16'h8000, 16'h7fff));
    send_frame(pose_frame(1'b1, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h7fff, 16'h8000));
    send_frame(pose_frame(1'b0, 16'h1234, 16'hfedc, 16'h0001, 16'h8000, 16'hffff, 16'h5a5a));
    send_frame(pose_frame(1'b0, '0, '0, '0, '0, '0, 16'hffff));

    // unused index is ignored; length below range on a longer history, any flip spins
    drain();
    write_reg(CFG_SPARE_IDX, 8'hff);
    write_setting(0, 0, 1);
    spin_seq = 6'b110001;
    for (int i = 0; i < 6; i++) send_frame(random_frame(spin_seq[i]));

    // length above range refills the window; zero hold drops a miss
    drain();
    write_setting(8'hff, 31, 0);
    send_frame(random_frame(1'b1));
    send_frame(random_frame(1'b0));
    send_frame(random_frame(1'b0));

    // short window, toggling flags cross the threshold
    drain();
    write_setting(3, 1, 255);
    toggle_seq = 6'b010101;
    for (int i = 0; i < 6; i++) send_frame(random_frame(toggle_seq[i]));

    det = 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin wlen = 2;     thr = 0;  hold = 255; end
        1: begin wlen = 32;    thr = 31; hold = 0;   end
        2: begin wlen = 8'hff; thr = 15; hold = 1;   end
        default: begin
          case ($urandom_range(5))
            0: wlen = $urandom_range(0, 1);
            1: wlen = $urandom_range(33, 255);
            2: wlen = 2;
            3: wlen = 32;
            default: wlen = $urandom_range(3, 31);
          endcase
          case ($urandom_range(3))
            0: thr = 0;
            1: thr = 31;
            default: thr = $urandom_range(0, 12);
          endcase
          case ($urandom_range(3))
            0: hold = 0;
            1: hold = 255;
            default: hold = $urandom_range(1, 20);
          endcase
        end
      endcase
      write_setting(wlen, thr, hold);
      calm = (ph == 4);
      case ($urandom_range(4))
        0: flip_pct = 3;
        1: flip_pct = 10;
        2: flip_pct = 25;
        3: flip_pct = 50;
        default: flip_pct = 85;
      endcase
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        if ($urandom_range(99) < flip_pct) det = !det;
        send_frame(random_frame(det));
      end
    end
    calm = 1'b0;
    drain();

    $display("covered %0d frames over %0d register settings", poses.frames_seen, settings_used);
    $display("reports checked: %0d detect, %0d coast, %0d spin, %0d mismatches",
             poses.kind_seen[KIND_DETECT], poses.kind_seen[KIND_COAST],
             poses.kind_seen[KIND_SPIN], poses.mismatches);
    if (poses.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
design/ftht_pkg.sv
design/ftht_flip_scan.sv
design/ftht_out_reg.sv
design/target_flicker_hold_tracker.sv
tb/ftht_tb_pkg.sv
tb/tb_target_flicker_hold_tracker.sv
